// File: hdl/srf_pkg.sv
package srf_pkg;

  localparam int RegWords = 22;
  localparam int RegIdxW = $clog2(RegWords);
  localparam int WaveWords = 16;
  localparam int WaveIdxW = $clog2(WaveWords);
  localparam int Channels = 4;

  localparam logic [15:0] REG_BASE = 16'hFF10;
  localparam logic [15:0] REG_LAST = 16'hFF25;
  localparam logic [15:0] STATUS_ADDR = 16'hFF26;
  localparam logic [15:0] WAVE_BASE = 16'hFF30;

  localparam logic [7:0] STATUS_FIXED = 8'h70;
  localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

  localparam logic [RegIdxW-1:0] IDX_HOLE_A = RegIdxW'(5);
  localparam logic [RegIdxW-1:0] IDX_HOLE_B = RegIdxW'(15);
  localparam logic [RegIdxW-1:0] IDX_ENV1 = RegIdxW'(2);
  localparam logic [RegIdxW-1:0] IDX_ENV2 = RegIdxW'(7);
  localparam logic [RegIdxW-1:0] IDX_WAVE_DAC = RegIdxW'(10);
  localparam logic [RegIdxW-1:0] IDX_ENV4 = RegIdxW'(17);
  localparam logic [RegIdxW-1:0] IDX_TRIG1 = RegIdxW'(4);
  localparam logic [RegIdxW-1:0] IDX_TRIG2 = RegIdxW'(9);
  localparam logic [RegIdxW-1:0] IDX_TRIG3 = RegIdxW'(14);
  localparam logic [RegIdxW-1:0] IDX_TRIG4 = RegIdxW'(19);

  typedef struct packed {
    logic is_wave;
    logic is_status;
    logic is_reg;
    logic [RegIdxW-1:0] reg_idx;
    logic [WaveIdxW-1:0] wave_idx;
  } addr_dec_t;

  typedef enum logic [2:0] {
    KIND_WRITE,
    KIND_WAVE,
    KIND_STATUS,
    KIND_REG,
    KIND_NONE
  } beat_kind_t;

  function automatic logic [7:0] read_mask(input logic [RegIdxW-1:0] idx);
    logic [7:0] m;
    unique case (idx)
      5'd0: m = 8'h80;
      5'd1: m = 8'h3F;
      5'd2: m = 8'h00;
      5'd3: m = 8'hFF;
      5'd4: m = 8'hBF;
      5'd5: m = 8'hFF;
      5'd6: m = 8'h3F;
      5'd7: m = 8'h00;
      5'd8: m = 8'hFF;
      5'd9: m = 8'hBF;
      5'd10: m = 8'h7F;
      5'd11: m = 8'hFF;
      5'd12: m = 8'h9F;
      5'd13: m = 8'hFF;
      5'd14: m = 8'hBF;
      5'd15: m = 8'hFF;
      5'd16: m = 8'hFF;
      5'd17: m = 8'h00;
      5'd18: m = 8'h00;
      5'd19: m = 8'hBF;
      5'd20: m = 8'h00;
      5'd21: m = 8'h00;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

// File: hdl/sound_register_file_unit.sv
// Bus register file of a four-channel sound generator: pulse, wave, noise and mixer
// registers at 0xFF10-0xFF26 and 16 bytes of wave RAM at 0xFF30-0xFF3F. Each input beat
// is one bus access and yields exactly one output beat: the masked byte for a read, or
// 0xFF and the mask of channels triggered for a write. The block takes one beat per
// cycle while the output side is not stalled; the synchronous read of the register or
// wave memory happens at the edge that takes the access, and the output register loads
// when the held result advances to the output.
// Register and wave memories are written at the accept edge, so a read that follows a
// write sees the new byte. Power-off clears the registers at once through per-entry
// valid bits, and wave RAM entries read as zero until first written through valid bits
// of their own; no clearing pass is needed after reset.
module sound_register_file_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
  input  logic        s_tuser,   // op: 0 read, 1 write
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // read_data[7:0], trigger_mask[11:8], zero[15:12]
);
  import srf_pkg::*;

  addr_dec_t dec;
  logic [7:0] wdata;
  logic accept, wr, reg_wr;

  logic power, power_next;
  logic [Channels-1:0] active, active_next;
  logic [Channels-1:0] dac, dac_next;
  logic [RegWords-1:0] valid, valid_next;
  logic [WaveWords-1:0] wave_valid, wave_valid_next;
  logic [Channels-1:0] trig;

  logic [7:0] sound_mem [RegWords];
  logic [7:0] wave_mem [WaveWords];
  logic [7:0] sound_rd, wave_rd;

  logic p1_valid, p1_adv;
  beat_kind_t p1_kind, kind;
  logic [7:0] p1_mask, p1_status;
  logic p1_hit, p1_wave_hit;
  logic [Channels-1:0] p1_trig;
  logic [15:0] result;

  srf_decode u_dec (
    .address(s_tdata[15:0]),
    .dec(dec)
  );

  assign wdata = s_tdata[23:16];
  assign p1_adv = p1_valid && (!m_tvalid || m_tready);
  assign s_tready = !p1_valid || p1_adv;
  assign accept = s_tvalid && s_tready;
  assign wr = accept && s_tuser;
  assign reg_wr = wr && power && dec.is_reg && !dec.is_status
                  && (dec.reg_idx != IDX_HOLE_A) && (dec.reg_idx != IDX_HOLE_B);

  always_comb begin
    power_next = power;
    active_next = active;
    dac_next = dac;
    valid_next = valid;
    wave_valid_next = wave_valid;
    trig = '0;
    if (wr && dec.is_wave) begin
      wave_valid_next[dec.wave_idx] = 1'b1;
    end
    if (wr && dec.is_status) begin
      if (wdata[7]) begin
        power_next = 1'b1;
      end else begin
        power_next = 1'b0;
        active_next = '0;
        dac_next = '0;
        valid_next = '0;
      end
    end else if (reg_wr) begin
      valid_next[dec.reg_idx] = 1'b1;
      unique case (dec.reg_idx)
        IDX_ENV1: dac_next[0] = |wdata[7:3];
        IDX_ENV2: dac_next[1] = |wdata[7:3];
        IDX_WAVE_DAC: dac_next[2] = wdata[7];
        IDX_ENV4: dac_next[3] = |wdata[7:3];
        IDX_TRIG1: trig[0] = wdata[7];
        IDX_TRIG2: trig[1] = wdata[7];
        IDX_TRIG3: trig[2] = wdata[7];
        IDX_TRIG4: trig[3] = wdata[7];
        default: ;
      endcase
      active_next = (active_next & dac_next) | (trig & dac);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power <= 1'b0;
      active <= '0;
      dac <= '0;
      valid <= '0;
      wave_valid <= '0;
    end else begin
      power <= power_next;
      active <= active_next;
      dac <= dac_next;
      valid <= valid_next;
      wave_valid <= wave_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (reg_wr) begin
      sound_mem[dec.reg_idx] <= wdata;
    end
    if (accept && !s_tuser && dec.is_reg && !dec.is_status) begin
      sound_rd <= sound_mem[dec.reg_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr && dec.is_wave) begin
      wave_mem[dec.wave_idx] <= wdata;
    end
    if (accept && !s_tuser && dec.is_wave) begin
      wave_rd <= wave_mem[dec.wave_idx];
    end
  end

  always_comb begin
    priority if (s_tuser) kind = KIND_WRITE;
    else if (dec.is_wave) kind = KIND_WAVE;
    else if (dec.is_status) kind = KIND_STATUS;
    else if (dec.is_reg) kind = KIND_REG;
    else kind = KIND_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (p1_adv) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_kind <= kind;
      p1_mask <= read_mask(dec.reg_idx);
      p1_hit <= valid[dec.reg_idx];
      p1_wave_hit <= wave_valid[dec.wave_idx];
      p1_status <= STATUS_FIXED | {power, 7'b0} | {4'b0, active};
      p1_trig <= trig;
    end
  end

  always_comb begin
    unique case (p1_kind)
      KIND_WRITE: result = {4'b0, p1_trig, UNMAPPED_BYTE};
      KIND_WAVE: result = {8'b0, p1_wave_hit ? wave_rd : 8'h00};
      KIND_STATUS: result = {8'b0, p1_status};
      KIND_REG: result = {8'b0, (p1_hit ? sound_rd : 8'h00) | p1_mask};
      default: result = {8'b0, UNMAPPED_BYTE};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (p1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      m_tdata <= result;
    end
  end

endmodule

// File: hdl/srf_decode.sv
module srf_decode (
  input  logic [15:0]         address,
  output srf_pkg::addr_dec_t  dec
);
  import srf_pkg::*;

  logic [RegIdxW-1:0] offset;

  assign offset = address[RegIdxW-1:0] - REG_BASE[RegIdxW-1:0];

  always_comb begin
    dec.is_wave = (address[15:WaveIdxW] == WAVE_BASE[15:WaveIdxW]);
    dec.is_status = (address == STATUS_ADDR);
    dec.is_reg = (address >= REG_BASE) && (address <= REG_LAST);
    dec.reg_idx = offset;
    dec.wave_idx = address[WaveIdxW-1:0];
  end

endmodule

// File: hdl/srf_checker.sv
module srf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("Input beat changed while waiting.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Output beat changed while stalled.");

  a_trig_onehot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[11:8]) && (m_tdata[15:12] == 4'b0))
    else $error("More than one channel triggered by one beat.");

  a_trig_is_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[11:8] != 4'b0) |-> (m_tdata[7:0] == 8'hFF))
    else $error("Trigger reported on a beat whose data is not a write result.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Output beat valid right after reset.");

endmodule

bind sound_register_file_unit srf_checker u_srf_checker (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata(s_tdata),
  .s_tuser(s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import srf_pkg::*;

  localparam logic OP_READ = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int CH_PULSE1 = 0;
  localparam int CH_PULSE2 = 1;
  localparam int CH_WAVE = 2;
  localparam int CH_NOISE = 3;

  localparam logic [15:0] WAVE_END = 16'hFF3F;
  localparam logic [15:0] LAST_HOLE = 16'hFF2F;
  localparam int REG_DEPTH = 23;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 6;

  // Bits that always read back as one, entry 0 in the lowest byte.
  localparam logic [8*RegWords-1:0] UNREADABLE = {
    8'h00, 8'h00, 8'hBF, 8'h00, 8'h00, 8'hFF,
    8'hFF, 8'hBF, 8'hFF, 8'h9F, 8'hFF, 8'h7F,
    8'hBF, 8'hFF, 8'h00, 8'h3F,
    8'hFF, 8'hBF, 8'hFF, 8'h00, 8'h3F, 8'h80
  };

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  read_data;
    logic [3:0]  trig;
  } bus_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // address[15:0], write_data[23:16]
  logic        s_tuser = 1'b0; // op: 0 read, 1 write
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // read_data[7:0], trigger_mask[11:8], zero[15:12]

  logic [7:0] psg_regs [0:REG_DEPTH-1];
  logic [7:0] wave_ram [0:WaveWords-1];
  logic       power_on;
  logic [3:0] chan_on;

  bus_result_t pending_results[$];
  bus_result_t got;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int err_count = 0;
  int items_sent = 0;
  int reads_sent = 0;
  int writes_sent = 0;
  int triggers_seen = 0;
  int results_checked = 0;
  int idle_cycles = 0;

  sound_register_file_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic dac_enabled(input int ch);
    logic on;
    case (ch)
      CH_PULSE1: on = psg_regs[IDX_ENV1][7:3] != 5'd0;
      CH_PULSE2: on = psg_regs[IDX_ENV2][7:3] != 5'd0;
      CH_WAVE: on = psg_regs[IDX_WAVE_DAC][7];
      default: on = psg_regs[IDX_ENV4][7:3] != 5'd0;
    endcase
    return on;
  endfunction

  function automatic void clear_registers();
    int i;
    for (i = 0; i < REG_DEPTH; i++) psg_regs[i] = 8'h00;
    chan_on = 4'h0;
  endfunction

  function automatic bus_result_t predict_access(input logic op, input logic [15:0] addr,
                                                 input logic [7:0] data);
    bus_result_t r;
    logic [RegIdxW-1:0] idx;
    logic in_regs;
    logic is_trig;
    int ch;
    r.op = op;
    r.addr = addr;
    r.read_data = UNMAPPED_BYTE;
    r.trig = 4'h0;
    idx = RegIdxW'(addr - REG_BASE);
    in_regs = addr >= REG_BASE && addr <= REG_LAST;
    is_trig = 1'b0;
    ch = CH_PULSE1;
    if (op == OP_WRITE) begin
      if (addr >= WAVE_BASE && addr <= WAVE_END) begin
        wave_ram[addr[3:0]] = data;
      end else if (addr == STATUS_ADDR) begin
        power_on = data[7];
        if (!data[7]) clear_registers();
      end else if (power_on && in_regs && idx != IDX_HOLE_A && idx != IDX_HOLE_B) begin
        psg_regs[idx] = data;
        case (idx)
          IDX_ENV1: if (!dac_enabled(CH_PULSE1)) chan_on[CH_PULSE1] = 1'b0;
          IDX_ENV2: if (!dac_enabled(CH_PULSE2)) chan_on[CH_PULSE2] = 1'b0;
          IDX_WAVE_DAC: if (!dac_enabled(CH_WAVE)) chan_on[CH_WAVE] = 1'b0;
          IDX_ENV4: if (!dac_enabled(CH_NOISE)) chan_on[CH_NOISE] = 1'b0;
          IDX_TRIG1: begin is_trig = 1'b1; ch = CH_PULSE1; end
          IDX_TRIG2: begin is_trig = 1'b1; ch = CH_PULSE2; end
          IDX_TRIG3: begin is_trig = 1'b1; ch = CH_WAVE; end
          IDX_TRIG4: begin is_trig = 1'b1; ch = CH_NOISE; end
          default: ;
        endcase
        if (is_trig && data[7]) begin
          r.trig[ch] = 1'b1;
          if (dac_enabled(ch)) chan_on[ch] = 1'b1;
        end
      end
    end else begin
      if (addr >= WAVE_BASE && addr <= WAVE_END) begin
        r.read_data = wave_ram[addr[3:0]];
      end else if (addr == STATUS_ADDR) begin
        r.read_data = STATUS_FIXED | {power_on, 3'b000, chan_on};
      end else if (in_regs) begin
        r.read_data = psg_regs[idx] | UNREADABLE[idx*8 +: 8];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 60) $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic send_access(input logic op, input logic [15:0] addr, input logic [7:0] data);
    bus_result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {data, addr};
    do @(posedge clk); while (!s_tready);
    r = predict_access(op, addr, data);
    pending_results.push_back(r);
    items_sent++;
    if (op == OP_WRITE) writes_sent++;
    else reads_sent++;
    if (r.trig != 4'h0) triggers_seen++;
  endtask

  task automatic bus_write(input logic [15:0] addr, input logic [7:0] data);
    send_access(OP_WRITE, addr, data);
  endtask

  task automatic bus_read(input logic [15:0] addr);
    send_access(OP_READ, addr, 8'($urandom_range(255)));
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat 0x%04h with no access pending", m_tdata));
      end else begin
        got = pending_results.pop_front();
        results_checked++;
        if (m_tdata[7:0] !== got.read_data)
          report_mismatch($sformatf("op %0d addr 0x%04h: read_data 0x%02h, want 0x%02h",
                                    got.op, got.addr, m_tdata[7:0], got.read_data));
        if (m_tdata[11:8] !== got.trig)
          report_mismatch($sformatf("op %0d addr 0x%04h: trigger_mask 0x%01h, want 0x%01h",
                                    got.op, got.addr, m_tdata[11:8], got.trig));
        if (m_tdata[15:12] !== 4'h0)
          report_mismatch($sformatf("op %0d addr 0x%04h: pad bits 0x%01h not zero",
                                    got.op, got.addr, m_tdata[15:12]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic test_reset_state();
    bus_read(STATUS_ADDR);
    bus_read(REG_BASE);
    bus_read(16'h0000);
    bus_read(16'hFFFF);
  endtask

  task automatic test_unpowered_writes();
    bus_write(REG_BASE + IDX_ENV1, 8'hF0);
    bus_read(REG_BASE + IDX_ENV1);
    bus_write(WAVE_BASE, 8'hA5);
    bus_write(WAVE_END, 8'h5A);
    bus_read(WAVE_END);
  endtask

  task automatic test_channel_enables();
    bus_write(STATUS_ADDR, 8'h80);
    bus_write(REG_BASE + IDX_ENV1, 8'hF0);
    bus_write(REG_BASE + IDX_TRIG1, 8'h80);
    bus_write(REG_BASE + IDX_ENV2, 8'h07);
    bus_write(REG_BASE + IDX_TRIG2, 8'hFF);
    bus_write(REG_BASE + IDX_WAVE_DAC, 8'h80);
    bus_write(REG_BASE + IDX_TRIG3, 8'hC7);
    bus_write(REG_BASE + IDX_ENV4, 8'h08);
    bus_write(REG_BASE + IDX_TRIG4, 8'h80);
    bus_read(STATUS_ADDR);
    bus_write(REG_BASE + IDX_WAVE_DAC, 8'h7F);
    bus_write(REG_BASE + IDX_ENV4, 8'h07);
    bus_read(STATUS_ADDR);
  endtask

  task automatic test_unmapped_holes();
    bus_write(REG_BASE + IDX_HOLE_A, 8'hFF);
    bus_write(REG_BASE + IDX_HOLE_B, 8'h00);
    bus_write(16'hFF27, 8'h12);
    bus_read(REG_BASE + IDX_HOLE_A);
    bus_read(REG_LAST);
  endtask

  task automatic test_power_off();
    bus_write(STATUS_ADDR, 8'h7F);
    bus_read(REG_BASE + IDX_ENV1);
    bus_read(STATUS_ADDR);
    bus_read(WAVE_BASE);
  endtask

  task automatic random_access();
    int pick;
    int ch;
    logic [15:0] dac_addr [0:3];
    logic [15:0] trig_addr [0:3];
    dac_addr = '{REG_BASE + IDX_ENV1, REG_BASE + IDX_ENV2,
                 REG_BASE + IDX_WAVE_DAC, REG_BASE + IDX_ENV4};
    trig_addr = '{REG_BASE + IDX_TRIG1, REG_BASE + IDX_TRIG2,
                  REG_BASE + IDX_TRIG3, REG_BASE + IDX_TRIG4};
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_access(1'($urandom_range(1)), 16'($urandom), 8'($urandom_range(255)));
    end else if (pick < 20) begin
      send_access(1'($urandom_range(1)), WAVE_BASE + 16'($urandom_range(15)),
                  8'($urandom_range(255)));
    end else if (pick < 30) begin
      if ($urandom_range(1)) bus_read(STATUS_ADDR);
      else bus_write(STATUS_ADDR, {($urandom_range(7) != 0), 7'($urandom)});
    end else if (pick < 45) begin
      // Set up a channel's DAC, trigger it and look at the enables.
      ch = $urandom_range(3);
      if (!power_on) bus_write(STATUS_ADDR, 8'h80 | 8'($urandom_range(127)));
      bus_write(dac_addr[ch], 8'($urandom_range(255)));
      bus_write(trig_addr[ch], 8'h80 | 8'($urandom_range(127)));
      bus_read(STATUS_ADDR);
    end else begin
      send_access(1'($urandom_range(1)),
                  REG_BASE + 16'($urandom_range(LAST_HOLE - REG_BASE)),
                  8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count,
                                     input bit pause_midway);
    int target;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    target = items_sent + count;
    while (items_sent < target) begin
      random_access();
      if (pause_midway && items_sent >= target - count / 2) begin
        wait_for_results();
        pause_midway = 1'b0;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < WaveWords; i++) wave_ram[i] = 8'h00;
    clear_registers();
    power_on = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_unpowered_writes();
    test_channel_enables();
    test_unmapped_holes();
    test_power_off();

    test_random_traffic(0, 0, 180, 1'b0);
    test_random_traffic(53, 0, 180, 1'b1);
    test_random_traffic(0, 53, 180, 1'b0);
    test_random_traffic(9, 9, 180, 1'b0);

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d accesses (%0d reads, %0d writes) with %0d channel triggers,",
             items_sent, reads_sent, writes_sent, triggers_seen);
    $display("%0d results checked under four source and sink stall mixes.", results_checked);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
